@@ hdl/hav_pkg.sv @@
// ----------------------------------------------------------------------------
// hav_pkg: shared constants and helpers for the haversine distance core
// Binary-angle format, CORDIC arctangent table and fixed scale factors.
// ----------------------------------------------------------------------------
package hav_pkg;

  // Binary angle, 2^-32 turn per LSB, wraps modulo one turn
  typedef logic [31:0] bam_t;

  // Quadrant code taken from the top two angle bits
  typedef enum logic [1:0] {
    QUAD_I,
    QUAD_II,
    QUAD_III,
    QUAD_IV
  } quad_e;

  // Configuration register indexes
  localparam logic REG_REF_LAT = 1'b0;
  localparam logic REG_REF_LON = 1'b1;

  localparam int unsigned ATAN_LEN    = 40;
  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  // Microdegrees per turn and half of it (rounding offset)
  localparam logic [63:0] UDEG_TURN = 64'd360000000;
  localparam logic [63:0] UDEG_HALF = 64'd180000000;

  // Pipeline depth of the degree-to-angle converter
  localparam int unsigned BAM_LAT = 5;

  // Root width of the integer square root (value up to 2^60)
  localparam int unsigned SQ_W = 31;

  // round(4 * pi * 6371000 * 128), split for two narrow products
  localparam logic [33:0] DIST_SCALE = 34'd10247724440;
  localparam logic [17:0] DIST_LO    = DIST_SCALE[17:0];
  localparam logic [15:0] DIST_HI    = DIST_SCALE[33:18];

  localparam logic [24:0] DIST_MAX = 25'd20015087;

  // Arctangent of 2^-i in 2^-32 turn units
  function automatic logic [31:0] atan_tab(int unsigned i);
    logic [31:0] v;
    v = '0;
    unique case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/haversine_great_circle_distance_core.sv @@
// Throughput: one point per cycle while the output is not stalled; the pipeline depth is
// set by the two CORDIC chains and the 31-stage square root.
// A stalled output freezes every stage at once; nothing is dropped or repeated.
// Reset clears all valid bits and sets the reference point to latitude 0, longitude 0.
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_core: great-circle distance to a reference
// Haversine formula on a 6371 km sphere, fixed point, result in metres.
// ----------------------------------------------------------------------------
module haversine_great_circle_distance_core #(
  parameter int unsigned CORDIC_ITERATIONS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic        [28:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [27:0] point_lat_i,
  input  logic signed [28:0] point_lon_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [24:0] distance_m_o
);

  localparam int unsigned SC_LAT  = CORDIC_ITERATIONS + 1;
  localparam int unsigned VEC_LAT = CORDIC_ITERATIONS + 1;
  localparam int unsigned LAT     = 1 + hav_pkg::BAM_LAT + SC_LAT + 3 + hav_pkg::SQ_W
                                    + VEC_LAT + 2;

  localparam logic signed [32:0] One33 = 33'(hav_pkg::Q30_ONE);

  function automatic logic signed [31:0] mul_q30(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return 32'(p >>> 30);
  endfunction

  logic signed [27:0] ref_lat_q;
  logic signed [28:0] ref_lon_q;
  logic [LAT-1:0]     vld_q;
  logic               adv;

  // Whole pipeline moves when the output slot is free or being taken
  assign adv         = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_lat_q <= '0;
      ref_lon_q <= '0;
      vld_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hav_pkg::REG_REF_LAT: ref_lat_q <= cfg_data_i[27:0];
          hav_pkg::REG_REF_LON: ref_lon_q <= cfg_data_i;
          default:              ref_lat_q <= ref_lat_q;
        endcase
      end
      if (adv) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
    end
  end

  // Stage 0: coordinate differences
  logic signed [29:0] dlat_q, dlon_q, rlat_q, plat_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dlat_q <= 30'(point_lat_i) - 30'(ref_lat_q);
      dlon_q <= 30'(point_lon_i) - 30'(ref_lon_q);
      rlat_q <= 30'(ref_lat_q);
      plat_q <= 30'(point_lat_i);
    end
  end

  hav_pkg::bam_t ang_dlat, ang_dlon, ang_rlat, ang_plat;

  hav_bam #(.SHIFT(31)) u_bam_dlat (
    .clk_i(clk_i), .en_i(adv), .deg_i(dlat_q), .ang_o(ang_dlat)
  );
  hav_bam #(.SHIFT(31)) u_bam_dlon (
    .clk_i(clk_i), .en_i(adv), .deg_i(dlon_q), .ang_o(ang_dlon)
  );
  hav_bam #(.SHIFT(32)) u_bam_rlat (
    .clk_i(clk_i), .en_i(adv), .deg_i(rlat_q), .ang_o(ang_rlat)
  );
  hav_bam #(.SHIFT(32)) u_bam_plat (
    .clk_i(clk_i), .en_i(adv), .deg_i(plat_q), .ang_o(ang_plat)
  );

  logic signed [31:0] sin_dlat, sin_dlon, cos_rlat, cos_plat;

  hav_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_dlat (
    .clk_i(clk_i), .en_i(adv), .ang_i(ang_dlat), .sin_o(sin_dlat), .cos_o()
  );
  hav_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_dlon (
    .clk_i(clk_i), .en_i(adv), .ang_i(ang_dlon), .sin_o(sin_dlon), .cos_o()
  );
  hav_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_rlat (
    .clk_i(clk_i), .en_i(adv), .ang_i(ang_rlat), .sin_o(), .cos_o(cos_rlat)
  );
  hav_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_plat (
    .clk_i(clk_i), .en_i(adv), .ang_i(ang_plat), .sin_o(), .cos_o(cos_plat)
  );

  // Products, sum and clamp of the haversine term
  logic signed [31:0] t1_q, so2_q, cc_q, t1b_q, t2_q;
  logic        [30:0] a_q, w_q;
  logic signed [32:0] asum;

  assign asum = 33'(t1b_q) + 33'(t2_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q  <= mul_q30(sin_dlat, sin_dlat);
      so2_q <= mul_q30(sin_dlon, sin_dlon);
      cc_q  <= mul_q30(cos_rlat, cos_plat);
      t1b_q <= t1_q;
      t2_q  <= mul_q30(so2_q, cc_q);
      if (asum[32]) begin
        a_q <= '0;
        w_q <= 31'(hav_pkg::Q30_ONE);
      end else if (asum > One33) begin
        a_q <= 31'(hav_pkg::Q30_ONE);
        w_q <= '0;
      end else begin
        a_q <= 31'(asum);
        w_q <= 31'(hav_pkg::Q30_ONE) - 31'(asum);
      end
    end
  end

  logic [30:0] root_a, root_w, theta;

  hav_isqrt u_sqrt_a (.clk_i(clk_i), .en_i(adv), .val_i(a_q), .root_o(root_a));
  hav_isqrt u_sqrt_w (.clk_i(clk_i), .en_i(adv), .val_i(w_q), .root_o(root_w));

  hav_vec #(.ITER(CORDIC_ITERATIONS)) u_vec (
    .clk_i(clk_i), .en_i(adv), .x_i(root_w), .y_i(root_a), .theta_o(theta)
  );

  // Scale the central angle to metres
  logic [46:0] dph_q;
  logic [48:0] dpl_q;
  logic [65:0] dsum;

  assign dsum = 66'({dph_q, 18'b0}) + 66'(dpl_q) + (66'(1) << 38);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dph_q        <= 47'(theta) * 47'(hav_pkg::DIST_HI);
      dpl_q        <= 49'(theta) * 49'(hav_pkg::DIST_LO);
      distance_m_o <= dsum[63:39];
    end
  end

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_m_o <= hav_pkg::DIST_MAX)
    else $error("distance beyond half circumference");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("pipeline valid bits moved during stall");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[LAT-2]))
    else $error("result appeared without a preceding stage");

endmodule

@@ hdl/hav_bam.sv @@
// ----------------------------------------------------------------------------
// hav_bam: microdegrees to binary angle
// Rounds d * 2^SHIFT / 360e6 half away from zero through a reciprocal
// multiply and one remainder correction, over five register stages.
// ----------------------------------------------------------------------------
module hav_bam #(
  parameter int unsigned SHIFT = 31
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [29:0] deg_i,
  output hav_pkg::bam_t      ang_o
);

  localparam logic [63:0] Recip  = (64'd1 << (SHIFT + 31)) / hav_pkg::UDEG_TURN;
  localparam logic [17:0] RecLo  = Recip[17:0];
  localparam logic [16:0] RecHi  = Recip[34:18];
  localparam logic [30:0] Div31  = hav_pkg::UDEG_TURN[30:0];
  localparam logic [30:0] Half31 = hav_pkg::UDEG_HALF[30:0];

  logic [29:0] mag_q;
  logic        neg1_q, neg2_q, neg3_q, neg4_q;
  logic [47:0] plo_q;
  logic [46:0] phi_q;
  logic [33:0] qe3_q, qe4_q;
  logic [30:0] prod_q;
  logic [65:0] sum;
  logic [30:0] rem;
  logic [33:0] quo;

  always_comb begin
    sum = 66'({phi_q, 18'b0}) + 66'(plo_q);
    // low 31 bits of d * 2^SHIFT are zero, so only the offset remains
    rem = Half31 - prod_q;
    quo = qe4_q + 34'(rem >= Div31);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= deg_i[29] ? 30'(-deg_i) : 30'(deg_i);
      neg1_q <= deg_i[29];
      plo_q  <= 48'(mag_q) * 48'(RecLo);
      phi_q  <= 47'(mag_q) * 47'(RecHi);
      neg2_q <= neg1_q;
      qe3_q  <= sum[64:31];
      neg3_q <= neg2_q;
      prod_q <= qe3_q[30:0] * Div31;
      qe4_q  <= qe3_q;
      neg4_q <= neg3_q;
      ang_o  <= neg4_q ? 32'(-quo) : 32'(quo);
    end
  end

endmodule

@@ hdl/hav_sincos.sv @@
// ----------------------------------------------------------------------------
// hav_sincos: pipelined rotation CORDIC
// One iteration per stage, then a clamp and quadrant fold to Q30 sin/cos.
// ----------------------------------------------------------------------------
module hav_sincos #(
  parameter int unsigned ITER = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  hav_pkg::bam_t      ang_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int unsigned CW = 33;
  localparam logic signed [CW-1:0] One = CW'(hav_pkg::Q30_ONE);

  logic signed [CW-1:0] x_q [ITER];
  logic signed [CW-1:0] y_q [ITER];
  logic signed [CW-1:0] z_q [ITER];
  hav_pkg::quad_e       quad_q [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    localparam logic signed [CW-1:0] Atan = CW'(hav_pkg::atan_tab(i));
    logic signed [CW-1:0] x_in, y_in, z_in;
    hav_pkg::quad_e       quad_in;

    if (i == 0) begin : g_first
      assign x_in    = CW'(hav_pkg::CORDIC_GAIN);
      assign y_in    = '0;
      assign z_in    = CW'(ang_i[29:0]);
      assign quad_in = hav_pkg::quad_e'(ang_i[31:30]);
    end else begin : g_next
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
      assign quad_in = quad_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i] <= quad_in;
        if (!z_in[CW-1]) begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - Atan;
        end else begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + Atan;
        end
      end
    end
  end

  logic signed [CW-1:0] xc, yc;
  logic signed [31:0]   xs, ys;

  always_comb begin
    if (x_q[ITER-1] > One) begin
      xc = One;
    end else if (x_q[ITER-1] < -One) begin
      xc = -One;
    end else begin
      xc = x_q[ITER-1];
    end
    if (y_q[ITER-1] > One) begin
      yc = One;
    end else if (y_q[ITER-1] < -One) begin
      yc = -One;
    end else begin
      yc = y_q[ITER-1];
    end
    xs = 32'(xc);
    ys = 32'(yc);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (quad_q[ITER-1])
        hav_pkg::QUAD_I: begin
          cos_o <= xs;
          sin_o <= ys;
        end
        hav_pkg::QUAD_II: begin
          cos_o <= -ys;
          sin_o <= xs;
        end
        hav_pkg::QUAD_III: begin
          cos_o <= -xs;
          sin_o <= -ys;
        end
        hav_pkg::QUAD_IV: begin
          cos_o <= ys;
          sin_o <= -xs;
        end
        default: begin
          cos_o <= xs;
          sin_o <= ys;
        end
      endcase
    end
  end

endmodule

@@ hdl/hav_isqrt.sv @@
// ----------------------------------------------------------------------------
// hav_isqrt: pipelined integer square root
// Floor root of val * 2^30, one result bit per register stage.
// ----------------------------------------------------------------------------
module hav_isqrt (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [hav_pkg::SQ_W-1:0] val_i,
  output logic [hav_pkg::SQ_W-1:0] root_o
);

  localparam int unsigned SW = hav_pkg::SQ_W;
  localparam int unsigned RW = 2 * SW - 1;
  localparam int unsigned TW = RW + 2;

  logic [RW-1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];

  for (genvar j = 0; j < SW; j++) begin : g_bit
    localparam int unsigned K = SW - 1 - j;
    logic [RW-1:0] rem_in;
    logic [SW-1:0] root_in;
    logic [TW-1:0] trial;
    logic          take;

    if (j == 0) begin : g_first
      assign rem_in  = {val_i, (SW - 1)'(0)};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k)
    always_comb begin
      trial = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
      take  = TW'(rem_in) >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (take) begin
          rem_q[j]  <= rem_in - RW'(trial);
          root_q[j] <= root_in | (SW'(1) << K);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[SW-1];

endmodule

@@ hdl/hav_vec.sv @@
// ----------------------------------------------------------------------------
// hav_vec: pipelined vectoring CORDIC
// Angle of (x, y) in 2^-32 turn, clamped to a quarter turn.
// ----------------------------------------------------------------------------
module hav_vec #(
  parameter int unsigned ITER = 24
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] x_i,
  input  logic [30:0] y_i,
  output logic [30:0] theta_o
);

  localparam int unsigned VW = 34;
  localparam logic signed [VW-1:0] One = VW'(hav_pkg::Q30_ONE);

  logic signed [VW-1:0] x_q [ITER];
  logic signed [VW-1:0] y_q [ITER];
  logic signed [VW-1:0] z_q [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    localparam logic signed [VW-1:0] Atan = VW'(hav_pkg::atan_tab(i));
    logic signed [VW-1:0] x_in, y_in, z_in;
    logic                 pos;

    if (i == 0) begin : g_first
      assign x_in = VW'(x_i);
      assign y_in = VW'(y_i);
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    assign pos = !y_in[VW-1] && (y_in != '0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (pos) begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + Atan;
        end else begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - Atan;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (z_q[ITER-1][VW-1]) begin
        theta_o <= '0;
      end else if (z_q[ITER-1] > One) begin
        theta_o <= 31'(One);
      end else begin
        theta_o <= 31'(z_q[ITER-1]);
      end
    end
  end

endmodule

@@ tb/sv/haversine_great_circle_distance_core_tb.sv @@
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_core_tb: self-checking distance testbench
// Streams query points against several reference points, predicts each
// distance with a bit-exact fixed-point model and checks every result.
// ----------------------------------------------------------------------------
module haversine_great_circle_distance_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITERS = 24;
  localparam int unsigned DRAIN_CYCLES = 2 * ITERS + 60;
  localparam longint LAT_MAX = 90000000;
  localparam longint LON_MAX = 180000000;

  localparam bit [31:0] ARCTAN_ROM [0:39] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic        [28:0] cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [27:0] point_lat_i = '0;
  logic signed [28:0] point_lon_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic        [24:0] distance_m_o;

  longint      home_lat;
  longint      home_lon;
  logic [24:0] distance_q[$];
  bit          failed;
  bit          no_stall;

  haversine_great_circle_distance_core #(
    .CORDIC_ITERATIONS(ITERS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .point_lat_i (point_lat_i),
    .point_lon_i (point_lon_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .distance_m_o(distance_m_o)
  );

  always #1 clk_i = ~clk_i;

  // ---- fixed-point distance predictor ----

  // round half away of d * 2^sh / one turn, wrapped to 32 bits
  function automatic bit [31:0] udeg_to_angle(longint d, int unsigned sh);
    bit [63:0] m;
    bit [63:0] q;
    m = (d < 0) ? 64'(-d) : 64'(d);
    q = ((m << sh) + 64'd180000000) / 64'd360000000;
    if (d < 0) q = -q;
    return q[31:0];
  endfunction

  function automatic void rotate_sin_cos(input bit [31:0] u, output longint s,
                                         output longint c);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = 652032874;
    y = 0;
    z = longint'(u[29:0]);
    for (int i = 0; i < ITERS && i < 40; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ARCTAN_ROM[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ARCTAN_ROM[i]);
      end
    end
    x = (x < -(64'sd1 << 30)) ? -(64'sd1 << 30) : ((x > (64'sd1 << 30)) ? (64'sd1 << 30) : x);
    y = (y < -(64'sd1 << 30)) ? -(64'sd1 << 30) : ((y > (64'sd1 << 30)) ? (64'sd1 << 30) : y);
    case (hav_pkg::quad_e'(u[31:30]))
      hav_pkg::QUAD_I:   begin c = x;  s = y;  end
      hav_pkg::QUAD_II:  begin c = -y; s = x;  end
      hav_pkg::QUAD_III: begin c = -x; s = -y; end
      default:           begin c = y;  s = -x; end
    endcase
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint int_sqrt(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint central_angle(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < ITERS && i < 40; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(ARCTAN_ROM[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ARCTAN_ROM[i]);
      end
    end
    return (z < 0) ? 0 : ((z > (64'sd1 << 30)) ? (64'sd1 << 30) : z);
  endfunction

  function automatic logic [24:0] predict_distance(logic signed [27:0] lat,
                                                   logic signed [28:0] lon);
    longint sa, ca, so, co, s1, c1, s2, c2, hav, theta;
    bit [63:0] dist_m;
    rotate_sin_cos(udeg_to_angle(longint'(lat) - home_lat, 31), sa, ca);
    rotate_sin_cos(udeg_to_angle(longint'(lon) - home_lon, 31), so, co);
    rotate_sin_cos(udeg_to_angle(home_lat, 32), s1, c1);
    rotate_sin_cos(udeg_to_angle(longint'(lat), 32), s2, c2);
    hav = q30_mul(sa, sa) + q30_mul(q30_mul(so, so), q30_mul(c1, c2));
    hav = (hav < 0) ? 0 : ((hav > (64'sd1 << 30)) ? (64'sd1 << 30) : hav);
    theta = central_angle(int_sqrt(64'(hav) << 30),
                          int_sqrt(64'((64'sd1 << 30) - hav) << 30));
    dist_m = (64'(theta) * 64'd10247724440 + (64'd1 << 38)) >> 39;
    return dist_m[24:0];
  endfunction

  // ---- result side ----

  always @(posedge clk_i) begin
    out_ready_i <= no_stall || ($urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (distance_q.size() == 0) begin
        $display("%0t: unexpected distance transfer, expected none, actual %0d",
                 $realtime, distance_m_o);
        failed = 1'b1;
      end else begin
        if (distance_m_o !== distance_q[0]) begin
          $display("%0t: distance_m mismatch, expected %0d, actual %0d",
                   $realtime, distance_q[0], distance_m_o);
          failed = 1'b1;
        end
        void'(distance_q.pop_front());
      end
    end
  end

  // ---- stimulus ----

  task automatic send_point(logic signed [27:0] lat, logic signed [28:0] lon);
    if (!no_stall && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    point_lat_i <= lat;
    point_lon_i <= lon;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    distance_q.push_back(predict_distance(lat, lon));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (distance_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reference(longint lat, longint lon);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= hav_pkg::REG_REF_LAT;
    cfg_data_i <= 29'(lat);
    @(posedge clk_i);
    cfg_idx_i  <= hav_pkg::REG_REF_LON;
    cfg_data_i <= 29'(lon);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    home_lat = longint'(signed'(28'(lat)));
    home_lon = longint'(signed'(29'(lon)));
  endtask

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(32'(2 * lim))) - lim;
  endfunction

  task automatic send_random_point();
    if ($urandom_range(99) < 85)
      send_point(28'(rand_span(LAT_MAX)), 29'(rand_span(LON_MAX)));
    else
      send_point(28'($urandom()), 29'($urandom()));
  endtask

  task automatic test_directed_points();
    send_point(0, 0);
    send_point(28'(LAT_MAX), 0);
    send_point(28'(-LAT_MAX), 0);
    send_point(0, 29'(LON_MAX));
    send_point(0, 29'(-LON_MAX));
    send_point(28'(LAT_MAX), 29'(LON_MAX));
    send_point(28'(-LAT_MAX), 29'(-LON_MAX));
    send_point(1, 1);
    send_point(-1, -1);
    // field extremes beyond the valid range wrap around
    send_point(28'sh7FF_FFFF, 29'sh0FFF_FFFF);
    send_point(28'sh800_0000, 29'sh1000_0000);
    send_point(28'sh7FF_FFFF, 29'sh1000_0000);
    send_point(28'sh800_0000, 29'sh0FFF_FFFF);
    send_point(45000000, 90000000);
    send_point(-45000000, -90000000);
  endtask

  task automatic test_reference_extremes();
    set_reference(LAT_MAX, LON_MAX);
    send_point(28'(-LAT_MAX), 29'(-LON_MAX));
    send_point(28'(LAT_MAX), 29'(LON_MAX));
    send_point(0, 0);
    for (int i = 0; i < 40; i++) send_random_point();
    set_reference(-LAT_MAX, -LON_MAX);
    send_point(28'(LAT_MAX), 0);
    send_point(28'(-LAT_MAX), 29'(-LON_MAX));
    for (int i = 0; i < 40; i++) send_random_point();
    set_reference(-(64'sd1 << 27), (64'sd1 << 28) - 1);
    for (int i = 0; i < 30; i++) send_random_point();
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 4; phase++) begin
      set_reference(rand_span(LAT_MAX), rand_span(LON_MAX));
      no_stall = (phase == 2);
      for (int i = 0; i < 230; i++) send_random_point();
      no_stall = 1'b0;
    end
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_random_point();
    // hold off until every distance has come back
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (distance_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 30; i++) send_random_point();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    home_lat = 0;
    home_lon = 0;
    test_directed_points();
    test_drain_pause();
    test_reference_extremes();
    test_random_stream();
    set_reference(0, 0);
    for (int i = 0; i < 20; i++) send_random_point();
    wait_idle();
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ haversine_great_circle_distance_core.f @@
hdl/hav_pkg.sv
hdl/hav_bam.sv
hdl/hav_sincos.sv
hdl/hav_isqrt.sv
hdl/hav_vec.sv
hdl/haversine_great_circle_distance_core.sv
tb/sv/haversine_great_circle_distance_core_tb.sv
